// ===== rtl/ffn_pkg.sv =====
// Shared types, widths and sequencer codes for the flat face normal unit.
`timescale 1ns / 1ps

package ffn_pkg;

   // Field widths
   localparam int CoordWidth  = 32;
   localparam int NormWidth   = 16;
   localparam int IndexWidth  = 32;

   // Normal datapath widths
   localparam int DiffWidth   = CoordWidth + 1;        // edge component
   localparam int ProdWidth   = 2 * DiffWidth;         // multiplier result
   localparam int CrossWidth  = ProdWidth + 1;         // exact cross component
   localparam int MagWidth    = CrossWidth - 2;        // cross magnitude
   localparam int UnitWidth   = 30;                    // normalized magnitude
   localparam int FracBits    = 14;                    // Q2.14 fraction
   localparam int SumWidth    = 64;                    // sum of squares / root
   localparam int RbitWidth   = 63;                    // root trial bit
   localparam int RootWidth   = 31;                    // final root
   localparam int NumWidth    = UnitWidth + FracBits + 1;
   localparam int QuoWidth    = 16;
   localparam int DvsWidth    = NumWidth + 1;
   localparam int StepWidth   = 5;
   localparam int ShiftWidth  = 6;

   // Last step of each iterative phase
   localparam logic [StepWidth-1:0] CrossLastStep  = 5'd6;
   localparam logic [StepWidth-1:0] NormLastStep   = 5'd6;
   localparam logic [StepWidth-1:0] SqSumLastStep  = 5'd3;
   localparam logic [StepWidth-1:0] SqrtLastStep   = 5'd31;
   localparam logic [StepWidth-1:0] DivideLastStep = 5'd15;

   localparam logic [RbitWidth-1:0] SqrtBitInit = {1'b1, {(RbitWidth-1){1'b0}}};
   localparam logic [NormWidth-1:0] NormSatMax  = 16'h7fff;

   // Corner count within a triangle
   localparam logic [1:0] PhaseFirst  = 2'd0;
   localparam logic [1:0] PhaseSecond = 2'd1;

   // Emitted corner within a triangle
   localparam logic [1:0] EmitFirst  = 2'd0;
   localparam logic [1:0] EmitSecond = 2'd1;
   localparam logic [1:0] EmitLast   = 2'd2;

   typedef struct packed {
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic signed [CoordWidth-1:0] pos_z;
      logic signed [CoordWidth-1:0] tex_u;
      logic signed [CoordWidth-1:0] tex_v;
   } ffn_vertex_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] out_x;
      logic signed [CoordWidth-1:0] out_y;
      logic signed [CoordWidth-1:0] out_z;
      logic signed [CoordWidth-1:0] out_u;
      logic signed [CoordWidth-1:0] out_v;
      logic signed [NormWidth-1:0]  norm_x;
      logic signed [NormWidth-1:0]  norm_y;
      logic signed [NormWidth-1:0]  norm_z;
      logic [IndexWidth-1:0]        vertex_index;
      logic                         last_of_triangle;
   } ffn_result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CROSS,
      ST_MAG,
      ST_NORM,
      ST_SQSUM,
      ST_SQRT,
      ST_DIVSET,
      ST_DIVIDE,
      ST_EMIT
   } ffn_state_type;

endpackage

// ===== rtl/ffn_channels.sv =====
// Valid/ready channel interfaces for vertex input and result output.
`timescale 1ns / 1ps

interface ffn_req_if import ffn_pkg::*; ();
   logic           valid;
   logic           ready;
   ffn_vertex_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ffn_rsp_if import ffn_pkg::*; ();
   logic           valid;
   logic           ready;
   ffn_result_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/flat_face_normal_unit_top.sv =====
// Flat face normal unit: per-triangle unit normal on a shared multiplier/shifter.
`timescale 1ns / 1ps

// Channel   Dir  Payload          Handshake
// req_ch    in   ffn_vertex_type  valid/ready, one vertex per item
// rsp_ch    out  ffn_result_type  valid/ready, three items per triangle
//
// First and second corners are taken and held.
// Third corner: normal work in cross, magnitude, normalize, sum of squares,
//   square root, divide setup and divide phases, on the one 33x33 multiplier
//   and the bit-per-cycle root and quotient loops; a degenerate triangle
//   skips to output straight after the magnitude step.
// Then three result items, one per cycle while rsp_ch.ready stays high.
// req_ch.ready is low from the third corner until the last result is taken.
// Synchronous active-high reset clears the sequencer, the corner count and
//   the running vertex index.

module flat_face_normal_unit_top import ffn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ffn_req_if.sink    req_ch,
   ffn_rsp_if.source  rsp_ch
);

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   ffn_state_type           state_ff,    state_in;
   logic [StepWidth-1:0]    step_ff,     step_in;
   logic [1:0]              phase_ff,    phase_in;
   logic [1:0]              emit_k_ff,   emit_k_in;
   logic [IndexWidth-1:0]   emit_cnt_ff, emit_cnt_in;

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   ffn_vertex_type              vtx_a_ff, vtx_a_in;
   ffn_vertex_type              vtx_b_ff, vtx_b_in;
   ffn_vertex_type              vtx_c_ff, vtx_c_in;
   logic signed [DiffWidth-1:0] d1_ff [3];
   logic signed [DiffWidth-1:0] d1_in [3];
   logic signed [DiffWidth-1:0] d2_ff [3];
   logic signed [DiffWidth-1:0] d2_in [3];
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic signed [CrossWidth-1:0] cross_ff [3];
   logic signed [CrossWidth-1:0] cross_in [3];
   logic [MagWidth-1:0]         mag_ff [3];
   logic [MagWidth-1:0]         mag_in [3];
   logic [2:0]                  neg_ff, neg_in;
   logic [SumWidth-1:0]         sum_ff, sum_in;
   logic [SumWidth-1:0]         root_ff, root_in;
   logic [RbitWidth-1:0]        rbit_ff, rbit_in;
   logic [NumWidth-1:0]         rem_ff [3];
   logic [NumWidth-1:0]         rem_in [3];
   logic [DvsWidth-1:0]         dvs_ff, dvs_in;
   logic [QuoWidth-1:0]         quo_ff [3];
   logic [QuoWidth-1:0]         quo_in [3];
   logic signed [NormWidth-1:0] norm_ff [3];
   logic signed [NormWidth-1:0] norm_in [3];

   // ------------------------------------------------------------------
   // Shared combinational signals
   // ------------------------------------------------------------------
   logic                        req_fire;
   logic                        rsp_fire;
   logic                        last_step;
   logic                        cross_zero;
   logic signed [DiffWidth-1:0] mul_a;
   logic signed [DiffWidth-1:0] mul_b;
   logic [UnitWidth-1:0]        unit [3];

   assign req_fire = req_ch.valid & req_ch.ready;
   assign rsp_fire = rsp_ch.valid & rsp_ch.ready;

   assign cross_zero = (cross_ff[0] == '0) && (cross_ff[1] == '0) && (cross_ff[2] == '0);

   // normalized magnitudes: top bits once the largest sits at the MSB
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit[i] = mag_ff[i][MagWidth-1 -: UnitWidth];
      end
   end

   always_comb begin
      case (state_ff)
         ST_CROSS:  last_step = (step_ff == CrossLastStep);
         ST_NORM:   last_step = (step_ff == NormLastStep);
         ST_SQSUM:  last_step = (step_ff == SqSumLastStep);
         ST_SQRT:   last_step = (step_ff == SqrtLastStep);
         ST_DIVIDE: last_step = (step_ff == DivideLastStep);
         default:   last_step = 1'b1;
      endcase
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && phase_ff[1]) begin
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: begin
            if (last_step) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            state_in = cross_zero ? ST_EMIT : ST_NORM;
         end
         ST_NORM: begin
            if (last_step) begin
               state_in = ST_SQSUM;
            end
         end
         ST_SQSUM: begin
            if (last_step) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (last_step) begin
               state_in = ST_DIVSET;
            end
         end
         ST_DIVSET: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (last_step) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire && (emit_k_ff == EmitLast)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer counters
   // ------------------------------------------------------------------
   always_comb begin
      step_in     = (state_in != state_ff) ? '0 : step_ff + 1'b1;
      phase_in    = phase_ff;
      emit_k_in   = emit_k_ff;
      emit_cnt_in = emit_cnt_ff;

      if (req_fire) begin
         phase_in = phase_ff[1] ? PhaseFirst : phase_ff + 1'b1;
      end
      if (rsp_fire) begin
         emit_cnt_in = emit_cnt_ff + 1'b1;
         emit_k_in   = (emit_k_ff == EmitLast) ? EmitFirst : emit_k_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      rsp_ch.valid = (state_ff == ST_EMIT);

      case (emit_k_ff)
         EmitFirst: begin
            rsp_ch.payload.out_x = vtx_a_ff.pos_x;
            rsp_ch.payload.out_y = vtx_a_ff.pos_y;
            rsp_ch.payload.out_z = vtx_a_ff.pos_z;
            rsp_ch.payload.out_u = vtx_a_ff.tex_u;
            rsp_ch.payload.out_v = vtx_a_ff.tex_v;
         end
         EmitSecond: begin
            rsp_ch.payload.out_x = vtx_b_ff.pos_x;
            rsp_ch.payload.out_y = vtx_b_ff.pos_y;
            rsp_ch.payload.out_z = vtx_b_ff.pos_z;
            rsp_ch.payload.out_u = vtx_b_ff.tex_u;
            rsp_ch.payload.out_v = vtx_b_ff.tex_v;
         end
         default: begin
            rsp_ch.payload.out_x = vtx_c_ff.pos_x;
            rsp_ch.payload.out_y = vtx_c_ff.pos_y;
            rsp_ch.payload.out_z = vtx_c_ff.pos_z;
            rsp_ch.payload.out_u = vtx_c_ff.tex_u;
            rsp_ch.payload.out_v = vtx_c_ff.tex_v;
         end
      endcase

      rsp_ch.payload.norm_x           = norm_ff[0];
      rsp_ch.payload.norm_y           = norm_ff[1];
      rsp_ch.payload.norm_z           = norm_ff[2];
      rsp_ch.payload.vertex_index     = emit_cnt_ff;
      rsp_ch.payload.last_of_triangle = (emit_k_ff == EmitLast);
   end

   // ------------------------------------------------------------------
   // Shared multiplier operand select
   // cross steps: c_x = d1y*d2z - d1z*d2y, c_y = d1z*d2x - d1x*d2z,
   //              c_z = d1x*d2y - d1y*d2x
   // ------------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_CROSS: begin
            case (step_ff)
               5'd0: begin mul_a = d1_ff[1]; mul_b = d2_ff[2]; end
               5'd1: begin mul_a = d1_ff[2]; mul_b = d2_ff[1]; end
               5'd2: begin mul_a = d1_ff[2]; mul_b = d2_ff[0]; end
               5'd3: begin mul_a = d1_ff[0]; mul_b = d2_ff[2]; end
               5'd4: begin mul_a = d1_ff[0]; mul_b = d2_ff[1]; end
               5'd5: begin mul_a = d1_ff[1]; mul_b = d2_ff[0]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_SQSUM: begin
            case (step_ff)
               5'd0: begin mul_a = DiffWidth'(unit[0]); mul_b = DiffWidth'(unit[0]); end
               5'd1: begin mul_a = DiffWidth'(unit[1]); mul_b = DiffWidth'(unit[1]); end
               5'd2: begin mul_a = DiffWidth'(unit[2]); mul_b = DiffWidth'(unit[2]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = ProdWidth'(mul_a) * ProdWidth'(mul_b);

   // ------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      logic signed [CrossWidth-1:0] term;
      logic [MagWidth-1:0]          or_word;
      logic [ShiftWidth-1:0]        norm_sh;
      logic [SumWidth-1:0]          trial;
      logic [RootWidth-1:0]         r_eff;
      logic [2:0]                   ge;
      logic [QuoWidth-1:0]          quo_next [3];
      logic [NormWidth-1:0]         q_sat;

      vtx_a_in = vtx_a_ff;
      vtx_b_in = vtx_b_ff;
      vtx_c_in = vtx_c_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      cross_in = cross_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sum_in   = sum_ff;
      root_in  = root_ff;
      rbit_in  = rbit_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      norm_in  = norm_ff;

      term    = CrossWidth'(prod_ff);
      or_word = mag_ff[0] | mag_ff[1] | mag_ff[2];
      norm_sh = '0;
      trial   = root_ff + SumWidth'(rbit_ff);
      r_eff   = (root_ff == '0) ? RootWidth'(1) : root_ff[RootWidth-1:0];
      ge      = '0;
      q_sat   = '0;
      for (int i = 0; i < 3; i++) begin
         quo_next[i] = quo_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (phase_ff == PhaseFirst) begin
                  vtx_a_in = req_ch.payload;
               end else if (phase_ff == PhaseSecond) begin
                  vtx_b_in = req_ch.payload;
               end else begin
                  // third corner: edge vectors relative to the first corner
                  vtx_c_in = req_ch.payload;
                  d1_in[0] = DiffWidth'(vtx_b_ff.pos_x) - DiffWidth'(vtx_a_ff.pos_x);
                  d1_in[1] = DiffWidth'(vtx_b_ff.pos_y) - DiffWidth'(vtx_a_ff.pos_y);
                  d1_in[2] = DiffWidth'(vtx_b_ff.pos_z) - DiffWidth'(vtx_a_ff.pos_z);
                  d2_in[0] = DiffWidth'(req_ch.payload.pos_x) - DiffWidth'(vtx_a_ff.pos_x);
                  d2_in[1] = DiffWidth'(req_ch.payload.pos_y) - DiffWidth'(vtx_a_ff.pos_y);
                  d2_in[2] = DiffWidth'(req_ch.payload.pos_z) - DiffWidth'(vtx_a_ff.pos_z);
               end
            end
         end

         ST_CROSS: begin
            // product of step n lands in prod_ff at step n+1
            case (step_ff)
               5'd1: cross_in[0] = term;
               5'd2: cross_in[0] = cross_ff[0] - term;
               5'd3: cross_in[1] = term;
               5'd4: cross_in[1] = cross_ff[1] - term;
               5'd5: cross_in[2] = term;
               5'd6: cross_in[2] = cross_ff[2] - term;
               default: cross_in = cross_ff;
            endcase
         end

         ST_MAG: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = cross_ff[i][CrossWidth-1];
               mag_in[i] = cross_ff[i][CrossWidth-1] ? MagWidth'(-cross_ff[i])
                                                     : MagWidth'(cross_ff[i]);
            end
            if (cross_zero) begin
               for (int i = 0; i < 3; i++) begin
                  norm_in[i] = '0;
               end
            end
         end

         ST_NORM: begin
            // binary search for the leading one, common shift for all three;
            // 65-bit word can hold 64 leading zeros, hence two single-bit steps
            case (step_ff)
               5'd0: norm_sh = (or_word[MagWidth-1 -: 32] == '0) ? 6'd32 : 6'd0;
               5'd1: norm_sh = (or_word[MagWidth-1 -: 16] == '0) ? 6'd16 : 6'd0;
               5'd2: norm_sh = (or_word[MagWidth-1 -: 8]  == '0) ? 6'd8  : 6'd0;
               5'd3: norm_sh = (or_word[MagWidth-1 -: 4]  == '0) ? 6'd4  : 6'd0;
               5'd4: norm_sh = (or_word[MagWidth-1 -: 2]  == '0) ? 6'd2  : 6'd0;
               5'd5: norm_sh = (or_word[MagWidth-1]       == 1'b0) ? 6'd1 : 6'd0;
               5'd6: norm_sh = (or_word[MagWidth-1]       == 1'b0) ? 6'd1 : 6'd0;
               default: norm_sh = '0;
            endcase
            for (int i = 0; i < 3; i++) begin
               mag_in[i] = mag_ff[i] << norm_sh;
            end
         end

         ST_SQSUM: begin
            sum_in  = (step_ff == '0) ? '0 : sum_ff + SumWidth'(prod_ff);
            root_in = '0;
            rbit_in = SqrtBitInit;
         end

         ST_SQRT: begin
            // restoring square root, one result bit per cycle
            if (sum_ff >= trial) begin
               sum_in  = sum_ff - trial;
               root_in = (root_ff >> 1) + SumWidth'(rbit_ff);
            end else begin
               root_in = root_ff >> 1;
            end
            rbit_in = rbit_ff >> 2;
         end

         ST_DIVSET: begin
            for (int i = 0; i < 3; i++) begin
               rem_in[i] = NumWidth'({unit[i], {FracBits{1'b0}}}) + NumWidth'(r_eff >> 1);
               quo_in[i] = '0;
            end
            dvs_in = DvsWidth'(r_eff) << (QuoWidth - 1);
         end

         ST_DIVIDE: begin
            // three restoring dividers against a shared shifting divisor
            for (int i = 0; i < 3; i++) begin
               ge[i] = ({1'b0, rem_ff[i]} >= dvs_ff);
               if (ge[i]) begin
                  rem_in[i] = rem_ff[i] - dvs_ff[NumWidth-1:0];
               end
               quo_next[i] = {quo_ff[i][QuoWidth-2:0], ge[i]};
               quo_in[i]   = quo_next[i];
            end
            dvs_in = dvs_ff >> 1;
            if (last_step) begin
               for (int i = 0; i < 3; i++) begin
                  q_sat      = quo_next[i][QuoWidth-1] ? NormSatMax : NormWidth'(quo_next[i]);
                  norm_in[i] = neg_ff[i] ? -$signed(q_sat) : $signed(q_sat);
               end
            end
         end

         default: begin
            norm_in = norm_ff;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= '0;
         phase_ff    <= PhaseFirst;
         emit_k_ff   <= EmitFirst;
         emit_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         phase_ff    <= phase_in;
         emit_k_ff   <= emit_k_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      vtx_a_ff <= vtx_a_in;
      vtx_b_ff <= vtx_b_in;
      vtx_c_ff <= vtx_c_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      prod_ff  <= prod_in;
      cross_ff <= cross_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      sum_ff   <= sum_in;
      root_ff  <= root_in;
      rbit_ff  <= rbit_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      norm_ff  <= norm_in;
   end

endmodule
